// ----- rtl/core/afra_pkg.sv -----
// Shared types, codes and constants for the adaptive frame rate adjuster.
// No dependencies; every module of the block imports this package.
package afra_pkg;

  localparam int RATE_FRAC_BITS = 8;
  localparam int TALLY_BITS     = 16;
  localparam int RATE_W         = 20;
  localparam int ELAPSED_W      = 16;
  localparam int MS_K_W         = 10;  // 1000 fits in 10 bits
  localparam int PROD_W         = TALLY_BITS + MS_K_W;
  localparam int NUM_W          = PROD_W + RATE_FRAC_BITS;
  localparam int HI_W           = NUM_W - RATE_W;
  localparam int STEP_W         = $clog2(RATE_W);
  localparam int CFG_IDX_W      = 2;

  localparam logic [MS_K_W-1:0] MS_PER_S = MS_K_W'(1000);

  localparam longint unsigned RATE_MAX_L = (64'd1 << RATE_W) - 64'd1;
  localparam longint unsigned BASE_L     = 64'd60 << RATE_FRAC_BITS;

  localparam logic [RATE_W-1:0] RATE_MAX = RATE_W'(RATE_MAX_L);
  localparam logic [RATE_W-1:0] ONE_FPS  = RATE_W'(64'd1 << RATE_FRAC_BITS);
  localparam logic [RATE_W-1:0] FIVE_FPS = RATE_W'(64'd5 << RATE_FRAC_BITS);
  localparam logic [RATE_W-1:0] BASE_RATE =
    RATE_W'((BASE_L > RATE_MAX_L) ? RATE_MAX_L : BASE_L);
  localparam logic [RATE_W-1:0] CFG_RATE_RST = RATE_W'(15360);
  localparam logic [ELAPSED_W-1:0] MIN_IVL_RST = ELAPSED_W'(500);

  localparam logic [1:0] FALL_RELOAD = 2'd2;
  localparam logic       RISE_RELOAD = 1'b1;

  typedef enum logic [1:0] {
    REQ_FRAME = 2'd0,
    REQ_CHECK = 2'd1,
    REQ_STOP  = 2'd2,
    REQ_FORCE = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_NOCHG   = 3'd0,
    ST_CHANGED = 3'd1,
    ST_SHORT   = 3'd2,
    ST_IDLE    = 3'd3,
    ST_FORCED  = 3'd4
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE   = 2'd0,
    CFG_RATE     = 2'd1,
    CFG_MIN_IVL  = 2'd2,
    CFG_RESERVED = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_EVAL,
    S_FIN
  } seq_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- rtl/core/afra_div.sv -----
// Serial restoring divider with saturation to the rate width.
// Depends on afra_pkg for widths and the status struct.
module afra_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [afra_pkg::NUM_W-1:0]      num,
  input  logic [afra_pkg::ELAPSED_W-1:0]  den,
  output afra_pkg::div_stat_t             stat,
  output logic [afra_pkg::RATE_W-1:0]     quot
);
  import afra_pkg::*;

  logic                  busy_r;
  logic                  done_r;
  logic                  sat_r;
  logic [STEP_W-1:0]     cnt_r;
  logic [ELAPSED_W-1:0]  rem_r;
  logic [ELAPSED_W-1:0]  den_r;
  logic [RATE_W-1:0]     quo_r;

  logic [HI_W+ELAPSED_W-1:0] hi_ext;
  logic [HI_W+ELAPSED_W-1:0] den_ext;
  logic                      sat_now;
  logic [ELAPSED_W:0]        trial;
  logic [ELAPSED_W:0]        diff;
  logic                      ge;

  // Quotient overflows the rate width exactly when the upper dividend bits
  // reach the divisor.
  assign hi_ext  = {{ELAPSED_W{1'b0}}, num[NUM_W-1:RATE_W]};
  assign den_ext = {{HI_W{1'b0}}, den};
  assign sat_now = (hi_ext >= den_ext);

  assign trial = {rem_r, quo_r[RATE_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign ge    = (trial >= {1'b0, den_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= !sat_now;
        done_r <= sat_now;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sat_r <= sat_now;
      den_r <= den;
      rem_r <= hi_ext[ELAPSED_W-1:0];
      quo_r <= num[RATE_W-1:0];
      cnt_r <= STEP_W'(RATE_W - 1);
    end else if (busy_r) begin
      rem_r <= ge ? diff[ELAPSED_W-1:0] : trial[ELAPSED_W-1:0];
      quo_r <= {quo_r[RATE_W-2:0], ge};
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = sat_r ? RATE_MAX : quo_r;

endmodule

// ----- rtl/core/adaptive_frame_rate_adjuster_top.sv -----
// Top level of the adaptive frame rate adjuster: request sequencer, rate
// decision and output register. Depends on afra_pkg and afra_div.
//
// Frame and stop words are absorbed without leaving the idle state. Force
// words, and checks that answer idle or short, stage the result as they are
// taken and then load the output register. A check that gets as far as
// measuring forms tally*1000, then runs the serial divider (load, then one
// quotient bit per cycle; the bit loop is skipped when the quotient
// saturates), with the floor applied as the quotient is captured, then makes
// the threshold and hysteresis decision and loads the output register. The
// next word is taken the cycle after the result loads, so measuring checks
// never overlap. The input is not ready while a word is in progress; a
// result word is staged and held until the output register frees up, and
// the input stays closed until then. There is no clearing pass after reset.
// Configuration writes take effect at once and must only be made while the
// block is idle.
module adaptive_frame_rate_adjuster_top (
  input  logic                              clk,
  input  logic                              rst_n,
  // request channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_req_type,
  input  logic [afra_pkg::ELAPSED_W-1:0]    in_elapsed_ms,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [2:0]                        out_status,
  output logic [afra_pkg::RATE_W-1:0]       out_new_rate,
  output logic [afra_pkg::RATE_W-1:0]       out_measured_rate,
  output logic                              out_direction_up,
  // configuration
  input  logic                              cfg_we,
  input  logic [afra_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [afra_pkg::RATE_W-1:0]       cfg_wdata
);
  import afra_pkg::*;

  // configuration registers
  logic                  enable_r;
  logic [RATE_W-1:0]     cfg_rate_r;
  logic [ELAPSED_W-1:0]  min_ivl_r;

  // block state
  logic                  running_r;
  logic [TALLY_BITS-1:0] tally_r;
  logic [RATE_W-1:0]     last_rate_r;
  logic [1:0]            fall_r;
  logic                  rise_r;

  // sequencer
  seq_state_t state_r, state_nxt;

  // datapath
  logic [PROD_W-1:0]     prod_r;
  logic [ELAPSED_W-1:0]  elapsed_r;
  logic [RATE_W-1:0]     m_r;

  // pending result
  status_t               res_status_r;
  logic [RATE_W-1:0]     res_new_r;
  logic [RATE_W-1:0]     res_meas_r;
  logic                  res_up_r;

  // output register
  logic                  out_valid_r;
  logic [2:0]            out_status_r;
  logic [RATE_W-1:0]     out_new_r;
  logic [RATE_W-1:0]     out_meas_r;
  logic                  out_up_r;

  // divider
  div_stat_t             dstat;
  logic [RATE_W-1:0]     quot;
  logic                  div_start;

  logic                  in_fire;
  logic                  out_free;
  logic                  load_out;
  req_t                  req;
  logic                  chk_live;
  logic                  chk_short;

  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign req       = req_t'(in_req_type);
  assign chk_live  = running_r && enable_r;
  assign chk_short = (in_elapsed_ms <= min_ivl_r) || (in_elapsed_ms == '0);

  afra_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   ({prod_r, {RATE_FRAC_BITS{1'b0}}}),
    .den   (elapsed_r),
    .stat  (dstat),
    .quot  (quot)
  );

  // ---------------------------------------------------------------------
  // Sequencer: next state and strobes.
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (req)
            REQ_FRAME, REQ_STOP: state_nxt = S_IDLE;
            REQ_FORCE:           state_nxt = S_FIN;
            REQ_CHECK:           state_nxt = (chk_live && !chk_short) ? S_MUL : S_FIN;
            default:             state_nxt = S_IDLE;
          endcase
        end
      end
      S_MUL: begin
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (dstat.done) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // hold the result until the output register frees up
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Rate decision: floor, threshold, hysteresis.
  // ---------------------------------------------------------------------
  logic [RATE_W-1:0]   floor_min;
  logic [RATE_W-1:0]   m_floor;
  logic [RATE_W-1:0]   diff_abs;
  logic [RATE_W+3:0]   diff_x10;
  logic [RATE_W+2:0]   m_x5;
  logic [RATE_W+1:0]   m_x25;
  logic [RATE_W-1:0]   rise_sat;
  logic                m_above;
  logic                pass;
  logic                ev_emit;
  logic [RATE_W-1:0]   ev_nr;
  logic [1:0]          ev_fall;
  logic                ev_rise;

  assign floor_min = (BASE_RATE < cfg_rate_r) ? BASE_RATE : cfg_rate_r;
  assign m_floor   = (quot < BASE_RATE && quot < cfg_rate_r) ? floor_min : quot;

  assign m_above  = (m_r > last_rate_r);
  assign diff_abs = m_above ? (m_r - last_rate_r) : (last_rate_r - m_r);
  assign diff_x10 = {1'b0, diff_abs, 3'b000} + {3'b000, diff_abs, 1'b0};
  assign pass     = (diff_abs > FIVE_FPS) && (diff_x10 > {4'b0000, last_rate_r});

  // 2.5x rise: (5m)/2, saturated
  assign m_x5     = {1'b0, m_r, 2'b00} + {3'b000, m_r};
  assign m_x25    = m_x5[RATE_W+2:1];
  assign rise_sat = (m_x25 > {2'b00, RATE_MAX}) ? RATE_MAX : m_x25[RATE_W-1:0];

  always_comb begin
    ev_emit = 1'b0;
    ev_nr   = '0;
    ev_fall = fall_r;
    ev_rise = rise_r;
    if (!pass) begin
      ev_fall = FALL_RELOAD;
      ev_rise = RISE_RELOAD;
    end else if (m_above) begin
      ev_fall = FALL_RELOAD;
      if (m_r <= cfg_rate_r) begin
        // snap straight to the configured rate
        ev_emit = 1'b1;
        ev_nr   = cfg_rate_r;
      end else if (rise_r != 1'b0) begin
        ev_rise = 1'b0;
      end else begin
        ev_emit = 1'b1;
        ev_nr   = rise_sat;
      end
    end else if (fall_r != 2'd0) begin
      ev_fall = fall_r - 1'b1;
      ev_rise = RISE_RELOAD;
    end else begin
      ev_emit = 1'b1;
      ev_nr   = m_r;
    end
  end

  // ---------------------------------------------------------------------
  // Configuration and block state.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b1;
      cfg_rate_r  <= CFG_RATE_RST;
      min_ivl_r   <= MIN_IVL_RST;
      running_r   <= 1'b0;
      tally_r     <= '0;
      last_rate_r <= CFG_RATE_RST;
      fall_r      <= FALL_RELOAD;
      rise_r      <= RISE_RELOAD;
    end else begin
      if (in_fire) begin
        unique case (req)
          REQ_FRAME: begin
            if (enable_r) begin
              running_r <= 1'b1;
              tally_r   <= tally_r + 1'b1;
            end
          end
          REQ_STOP: begin
            running_r <= 1'b0;
            tally_r   <= '0;
          end
          REQ_CHECK: begin
            if (chk_live) begin
              tally_r <= '0;
            end
          end
          REQ_FORCE: ;
          default: ;
        endcase
      end
      if (state_r == S_EVAL) begin
        fall_r <= ev_fall;
        rise_r <= ev_rise;
        if (ev_emit) begin
          last_rate_r <= ev_nr;
        end
      end
      if (cfg_we) begin
        unique case (cfg_idx_t'(cfg_index))
          CFG_ENABLE:  enable_r <= cfg_wdata[0];
          CFG_RATE: begin
            // drop writes below 1.0 fps
            if (cfg_wdata >= ONE_FPS) begin
              cfg_rate_r  <= cfg_wdata;
              last_rate_r <= cfg_wdata;
            end
          end
          CFG_MIN_IVL: min_ivl_r <= cfg_wdata[ELAPSED_W-1:0];
          CFG_RESERVED: ;
          default: ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------
  // Datapath and pending result.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_fire) begin
      prod_r     <= PROD_W'(tally_r) * PROD_W'(MS_PER_S);
      elapsed_r  <= in_elapsed_ms;
      res_meas_r <= '0;
      res_up_r   <= 1'b0;
      if (req == REQ_FORCE) begin
        res_status_r <= ST_FORCED;
        res_new_r    <= cfg_rate_r;
      end else if (!chk_live) begin
        res_status_r <= ST_IDLE;
        res_new_r    <= '0;
      end else begin
        res_status_r <= ST_SHORT;
        res_new_r    <= '0;
      end
    end
    if (state_r == S_DIV && dstat.done) begin
      m_r <= m_floor;
    end
    if (state_r == S_EVAL) begin
      res_status_r <= ev_emit ? ST_CHANGED : ST_NOCHG;
      res_new_r    <= ev_nr;
      res_meas_r   <= m_r;
      res_up_r     <= ev_emit && (ev_nr > last_rate_r);
    end
  end

  // ---------------------------------------------------------------------
  // Output register.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r <= res_status_r;
      out_new_r    <= res_new_r;
      out_meas_r   <= res_meas_r;
      out_up_r     <= res_up_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_new_rate      = out_new_r;
  assign out_measured_rate = out_meas_r;
  assign out_direction_up  = out_up_r;

`ifndef ASSERT_OFF
  // the divider never runs while the input side is open
  a_ready_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !dstat.busy)
    else $error("input ready while divider busy");

  // a divider result is always consumed by the decision step
  a_done_to_eval: assert property (@(posedge clk) disable iff (!rst_n)
    dstat.done |=> (state_r == S_EVAL))
    else $error("divider done outside the divide state");

  // the fall counter never exceeds its reload value
  a_fall_range: assert property (@(posedge clk) disable iff (!rst_n)
    fall_r != 2'd3)
    else $error("fall pass counter out of range");

  // an emitted change is never below 1.0 fps
  a_change_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_CHANGED) |-> (out_new_rate >= ONE_FPS))
    else $error("changed rate below 1.0 fps");
`endif

endmodule

// ----- verif/afra_rate_checker.sv -----
`timescale 1ns / 100ps
// Result checker for the adaptive frame rate adjuster: mirrors the register
// writes, predicts each result word and compares it. Uses afra_pkg.
module afra_rate_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic [1:0]                     in_req_type,
  input  logic [afra_pkg::ELAPSED_W-1:0] in_elapsed_ms,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic [2:0]                     out_status,
  input  logic [afra_pkg::RATE_W-1:0]    out_new_rate,
  input  logic [afra_pkg::RATE_W-1:0]    out_measured_rate,
  input  logic                           out_direction_up,
  input  logic                           cfg_we,
  input  logic [afra_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [afra_pkg::RATE_W-1:0]    cfg_wdata,
  output int                             fail_count,
  output int                             results_due
);
  import afra_pkg::*;

  typedef logic [RATE_W-1:0] rate_q_t;

  typedef struct packed {
    status_t status;
    rate_q_t new_rate;
    rate_q_t measured;
    logic    up;
  } rate_word_t;

  localparam rate_q_t FLOOR_Q = RATE_W'(60 << RATE_FRAC_BITS);
  localparam rate_q_t ONE_Q   = RATE_W'(1 << RATE_FRAC_BITS);
  localparam rate_q_t JUMP_Q  = RATE_W'(5 << RATE_FRAC_BITS);
  localparam rate_q_t SAT_Q   = '1;
  localparam logic [1:0] FALL_PASSES = 2'd2;
  localparam logic       RISE_PASSES = 1'b1;

  // register mirror
  logic                  en_q;
  rate_q_t               cfg_rate;
  logic [ELAPSED_W-1:0]  min_ivl;
  // block state mirror
  logic                  running;
  logic [TALLY_BITS-1:0] tally;
  rate_q_t               last_rate;
  logic [1:0]            fall_left;
  logic                  rise_left;

  rate_word_t rate_words_due[$];
  int         fails = 0;

  function automatic rate_q_t clip_rate(input logic [63:0] v);
    return (v > 64'(SAT_Q)) ? SAT_Q : v[RATE_W-1:0];
  endfunction

  task automatic queue_rate_word(input status_t st, input rate_q_t nr, input rate_q_t mr,
                                 input logic up);
    rate_word_t w;
    w.status   = st;
    w.new_rate = nr;
    w.measured = mr;
    w.up       = up;
    rate_words_due.push_back(w);
  endtask

  task automatic predict_rate_word(input req_t req, input logic [ELAPSED_W-1:0] ivl);
    logic [TALLY_BITS-1:0] count;
    rate_q_t               m;
    rate_q_t               d;
    rate_q_t               nr;
    case (req)
      REQ_FRAME: begin
        if (en_q) begin
          running = 1'b1;
          tally   = tally + 1'b1;
        end
      end
      REQ_STOP: begin
        running = 1'b0;
        tally   = '0;
      end
      REQ_FORCE: queue_rate_word(ST_FORCED, cfg_rate, '0, 1'b0);
      default: begin
        if (!running || !en_q) begin
          queue_rate_word(ST_IDLE, '0, '0, 1'b0);
          return;
        end
        count = tally;
        tally = '0;
        if (ivl <= min_ivl || ivl == '0) begin
          queue_rate_word(ST_SHORT, '0, '0, 1'b0);
          return;
        end
        m = clip_rate(((64'(count) * 64'd1000) << RATE_FRAC_BITS) / 64'(ivl));
        if (m < FLOOR_Q && m < cfg_rate)
          m = (FLOOR_Q < cfg_rate) ? FLOOR_Q : cfg_rate;
        d = (m > last_rate) ? m - last_rate : last_rate - m;
        if (!(d > JUMP_Q && 64'(d) * 64'd10 > 64'(last_rate))) begin
          fall_left = FALL_PASSES;
          rise_left = RISE_PASSES;
          queue_rate_word(ST_NOCHG, '0, m, 1'b0);
          return;
        end
        if (m > last_rate) begin
          fall_left = FALL_PASSES;
          if (m <= cfg_rate) begin
            nr = cfg_rate;
          end else if (rise_left) begin
            rise_left = 1'b0;
            queue_rate_word(ST_NOCHG, '0, m, 1'b0);
            return;
          end else begin
            nr = clip_rate((64'(m) * 64'd5) / 64'd2);
          end
        end else if (fall_left != 2'd0) begin
          fall_left = fall_left - 2'd1;
          rise_left = RISE_PASSES;
          queue_rate_word(ST_NOCHG, '0, m, 1'b0);
          return;
        end else begin
          nr = m;
        end
        queue_rate_word(ST_CHANGED, nr, m, nr > last_rate);
        last_rate = nr;
      end
    endcase
  endtask

  task automatic check_field(input string name, input rate_q_t want, input rate_q_t got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    rate_word_t w;
    if (!rst_n) begin
      en_q      = 1'b1;
      cfg_rate  = CFG_RATE_RST;
      min_ivl   = MIN_IVL_RST;
      running   = 1'b0;
      tally     = '0;
      last_rate = CFG_RATE_RST;
      fall_left = FALL_PASSES;
      rise_left = RISE_PASSES;
      rate_words_due.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (rate_words_due.size() == 0) begin
          $error("result word with no prediction: status %0d", out_status);
          fails++;
        end else begin
          w = rate_words_due.pop_front();
          check_field("status", rate_q_t'(w.status), rate_q_t'(out_status));
          check_field("new_rate", w.new_rate, out_new_rate);
          check_field("measured_rate", w.measured, out_measured_rate);
          check_field("direction_up", rate_q_t'(w.up), rate_q_t'(out_direction_up));
        end
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_ENABLE: en_q = cfg_wdata[0];
          CFG_RATE: begin
            if (cfg_wdata >= ONE_Q) begin
              cfg_rate  = cfg_wdata;
              last_rate = cfg_wdata;
            end
          end
          CFG_MIN_IVL: min_ivl = cfg_wdata[ELAPSED_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        predict_rate_word(req_t'(in_req_type), in_elapsed_ms);
    end
    results_due <= rate_words_due.size();
    fail_count  <= fails;
  end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps
// Top of the frame rate adjuster testbench: clock, reset, stimulus, receiver
// stalls and verdict. Depends on afra_pkg, the block top and afra_rate_checker.
module tb;
  import afra_pkg::*;

  localparam int SETTLE_CYCLES  = 40;    // quiet time before register writes
  localparam int STALL_LIMIT    = 5000;  // cycles without any accepted word
  localparam int SQUEEZE_CYCLES = 400;   // one long receiver hold-off

  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  logic                 clk           = 1'b0;
  logic                 rst_n         = 1'b0;
  logic                 in_valid      = 1'b0;
  logic                 in_ready;
  logic [1:0]           in_req_type   = REQ_FRAME;
  logic [ELAPSED_W-1:0] in_elapsed_ms = '0;
  logic                 out_valid;
  logic                 out_ready     = 1'b0;
  logic [2:0]           out_status;
  logic [RATE_W-1:0]    out_new_rate;
  logic [RATE_W-1:0]    out_measured_rate;
  logic                 out_direction_up;
  logic                 cfg_we        = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index     = CFG_ENABLE;
  logic [RATE_W-1:0]    cfg_wdata     = '0;

  int fail_count;
  int results_due;

  // Stimulus-side view of the registers, used only to shape the traffic.
  logic [RATE_W-1:0] rate_now = CFG_RATE_RST;
  int                min_now  = 500;

  idle_mode_t idle_mode   = IDLE_NONE;
  logic       squeeze     = 1'b0;
  logic       squeezed    = 1'b0;
  int         hold_left   = 0;
  int         words_sent  = 0;
  int         quiet_cycles = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  adaptive_frame_rate_adjuster_top dut (.*);

  afra_rate_checker chk (.*);

  // Idle chance in percent for one side of the block under the current mode.
  function automatic int idle_percent(input idle_mode_t m, input logic receiver);
    if (m == IDLE_BOTH)
      return 29;
    if ((m == IDLE_SEND && !receiver) || (m == IDLE_RECV && receiver))
      return 62;
    return 0;
  endfunction

  // Receiver: random stalls, plus one long hold-off when squeeze is raised.
  // While it holds, the sender keeps offering words so the block backs up.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (squeeze && !squeezed) begin
      squeezed  <= 1'b1;
      hold_left <= SQUEEZE_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= idle_percent(idle_mode, 1'b1));
    end
  end

  // Watchdog: end the run if no word moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one request word and hold it until accepted. Called right after a
  // rising edge; returns at the edge that took the word, with valid still high
  // so that a following word goes out back to back.
  task automatic send_word(input req_t req, input logic [ELAPSED_W-1:0] ivl);
    int idle_pct;
    idle_pct = idle_percent(idle_mode, 1'b0);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_req_type   <= req;
    in_elapsed_ms <= ivl;
    do @(posedge clk); while (!in_ready);
    words_sent++;
  endtask

  // Frame words ignore the elapsed field; fill it with noise anyway.
  task automatic send_frames(input int n);
    repeat (n) send_word(REQ_FRAME, ELAPSED_W'($urandom_range(0, 65535)));
  endtask

  // Drop valid, wait until every predicted result is in, then let any frame or
  // stop word still in flight finish before touching the registers.
  task automatic quiesce();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write; the spare cycle after it keeps cfg_we to a single
  // assignment per edge when writes follow one another.
  task automatic cfg_write(input cfg_idx_t idx, input logic [RATE_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_RATE:    if (data >= RATE_W'(1 << RATE_FRAC_BITS)) rate_now = data;
      CFG_MIN_IVL: min_now = int'(data[ELAPSED_W-1:0]);
      default: ;
    endcase
  endtask

  // Random traffic. Most of it is frame bursts closed by a check whose
  // interval clears the minimum and aims at a chosen rate; the target is
  // repeated a few times so that the rise and fall passes run out. The rest
  // is loose words of any kind with any elapsed value. Bursts shrink to fit
  // the words left in the budget.
  task automatic run_traffic(input int budget);
    int start;
    int fps;
    int ivl;
    int n;
    start = words_sent;
    while (words_sent - start < budget) begin
      if ($urandom_range(0, 99) < 78) begin
        case ($urandom_range(0, 5))
          0:       fps = $urandom_range(1, 20);
          1:       fps = $urandom_range(50, 70);
          2:       fps = $urandom_range(20, 120);
          3:       fps = $urandom_range(120, 600);
          4:       fps = int'(rate_now >> RATE_FRAC_BITS) + $urandom_range(0, 40) - 20;
          default: fps = $urandom_range(1000, 5000);
        endcase
        if (fps < 1)
          fps = 1;
        repeat ($urandom_range(1, 4)) begin
          if (words_sent - start < budget) begin
            ivl = min_now + 1 + $urandom_range(0, 120);
            if (ivl > 65535)
              ivl = 65535;
            n = ivl * fps / 1000;
            if (n > budget - (words_sent - start))
              n = budget - (words_sent - start);
            if (n < 1)
              n = 1;
            if (n > 150)
              n = 150;
            // now and then break the burst with a stop or a force
            if ($urandom_range(0, 9) == 0)
              send_word($urandom_range(0, 1) ? REQ_FORCE : REQ_STOP,
                        ELAPSED_W'($urandom_range(0, 65535)));
            send_frames(n);
            send_word(REQ_CHECK, ELAPSED_W'(ivl));
          end
        end
      end else begin
        repeat ($urandom_range(1, 6))
          send_word(req_t'($urandom_range(0, 3)), ELAPSED_W'($urandom_range(0, 65535)));
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed words, reset register values ----
    send_word(REQ_CHECK, 16'd1000);          // not armed yet: idle
    send_word(REQ_FORCE, 16'hFFFF);          // force answers even when idle
    send_word(REQ_FRAME, 16'd0);             // arm
    send_word(REQ_STOP, 16'd0);              // disarm and clear the tally
    send_word(REQ_CHECK, 16'd1000);          // idle again
    quiesce();
    cfg_write(CFG_MIN_IVL, 20'd0);
    send_frames(2);
    send_word(REQ_CHECK, 16'd0);             // zero interval is always short
    send_frames(5);
    send_word(REQ_CHECK, 16'd1);             // saturated rise: first pass held
    send_frames(5);
    send_word(REQ_CHECK, 16'd1);             // second rise: emit 2.5x, saturated
    // three slow checks: two fall passes held, then the floor is emitted
    repeat (3) begin
      send_word(REQ_FRAME, 16'd7);
      send_word(REQ_CHECK, 16'hFFFF);
    end
    quiesce();
    cfg_write(CFG_ENABLE, 20'd0);
    send_word(REQ_FRAME, 16'd0);             // dropped while disabled
    send_word(REQ_CHECK, 16'd1000);          // disabled: idle
    quiesce();
    cfg_write(CFG_ENABLE, 20'd1);
    // re-armed after enable
    send_frames(3);
    send_word(REQ_CHECK, 16'd1000);

    // ---- random phases, one register setting and idle mode each ----
    quiesce();
    cfg_write(CFG_MIN_IVL, 20'd20);
    idle_mode <= IDLE_NONE;
    run_traffic(300);

    // lowest configured rate, no minimum interval, sender gaps
    quiesce();
    cfg_write(CFG_RATE, 20'd256);
    cfg_write(CFG_MIN_IVL, 20'd0);
    idle_mode <= IDLE_SEND;
    run_traffic(300);

    // highest configured rate, receiver stalls and one long hold-off
    quiesce();
    cfg_write(CFG_RATE, 20'hFFFFF);
    cfg_write(CFG_MIN_IVL, 20'd5);
    idle_mode <= IDLE_RECV;
    squeeze   <= 1'b1;
    run_traffic(300);

    // random mid-range setting, both sides idle
    quiesce();
    cfg_write(CFG_RATE, RATE_W'($urandom_range(2560, 40000)));
    cfg_write(CFG_MIN_IVL, RATE_W'($urandom_range(0, 40)));
    idle_mode <= IDLE_BOTH;
    run_traffic(300);

    // reset-like minimum interval: longer frame bursts
    quiesce();
    cfg_write(CFG_RATE, 20'd7680);
    cfg_write(CFG_MIN_IVL, 20'd500);
    idle_mode <= IDLE_NONE;
    run_traffic(200);

    // disabled, upper data bits random: frames drop, checks answer idle
    quiesce();
    cfg_write(CFG_ENABLE, {19'($urandom_range(0, 524287)), 1'b0});
    idle_mode <= IDLE_BOTH;
    run_traffic(80);

    // widest minimum interval: every measuring check is short
    quiesce();
    cfg_write(CFG_ENABLE, {19'($urandom_range(0, 524287)), 1'b1});
    cfg_write(CFG_MIN_IVL, 20'hFFFF);
    cfg_write(CFG_RATE, 20'd30720);
    idle_mode <= IDLE_SEND;
    run_traffic(80);

    // a rate below 1.0 is ignored, the spare index does nothing
    quiesce();
    cfg_write(CFG_RATE, 20'd100);
    cfg_write(CFG_RESERVED, RATE_W'($urandom_range(0, 1048575)));
    cfg_write(CFG_RATE, RATE_W'($urandom_range(256, 1048575)));
    cfg_write(CFG_MIN_IVL, 20'd10);
    idle_mode <= IDLE_RECV;
    run_traffic(300);

    quiesce();
    if (fail_count == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
